// ----- hw/rtl/esck_pkg.sv -----
// Shared types, constants and step functions of the envelope space-charge kick datapath.
`default_nettype none

package esck_pkg;

    localparam int PREP_STAGES = 3;
    localparam int SQ_STEPS    = 64;
    localparam int KD_STEPS    = 64;
    localparam int KICK_STAGES = 4;

    localparam int DIV_DW = 96;
    localparam int DIV_RW = 97;
    localparam int DIV_QW = 63;
    localparam int SQ_RW  = 68;

    localparam logic [63:0] TERM_SAT  = 64'h4000_0000_0000_0000;
    localparam logic [40:0] KICK_SAT  = 41'h100_0000_0000;
    localparam logic [31:0] SLOPE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SLOPE_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_EMIT_X       = 3'd0,
        REG_EMIT_Y       = 3'd1,
        REG_SPACE_CHARGE = 3'd2,
        REG_DISPERSION   = 3'd3,
        REG_STEP_LENGTH  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [30:0] emit_x;
        logic [30:0] emit_y;
        logic [31:0] space_charge;
        logic [31:0] dispersion;
        logic [30:0] step_length;
    } cfg_t;

    typedef struct packed {
        logic [31:0] x_size;
        logic [31:0] x_slope;
        logic [31:0] y_size;
        logic [31:0] y_slope;
        logic [31:0] energy_spread;
    } item_t;

    typedef struct packed {
        logic [SQ_RW-1:0] rem;
        logic [63:0]      root;
        logic [127:0]     rad;
    } sqrt_t;

    typedef struct packed {
        logic [DIV_RW-1:0] rem;
        logic [DIV_QW-1:0] q;
        logic [DIV_QW-1:0] num;
        logic              ovf;
    } div_t;

    typedef struct packed {
        logic [127:0] rad;
        logic [95:0]  a3;
        logic [95:0]  b3;
        logic [61:0]  ex2;
        logic [61:0]  ey2;
        logic [31:0]  b;
        logic         a_zero;
        logic         b_zero;
        logic [31:0]  x_slope;
        logic [31:0]  y_slope;
    } prep_t;

    typedef struct packed {
        sqrt_t        sq;
        div_t         dx;
        div_t         dy;
        logic [95:0]  a3;
        logic [95:0]  b3;
        logic [31:0]  b;
        logic         a_zero;
        logic         b_zero;
        logic [31:0]  x_slope;
        logic [31:0]  y_slope;
    } rd_t;

    typedef struct packed {
        logic [63:0]       t;
        div_t              dg;
        logic [DIV_QW-1:0] qx;
        logic              ovfx;
        logic [DIV_QW-1:0] qy;
        logic              ovfy;
        logic              a_zero;
        logic              b_zero;
        logic [31:0]       x_slope;
        logic [31:0]       y_slope;
    } kd_t;

    typedef struct packed {
        logic [31:0] new_x_slope;
        logic [31:0] new_y_slope;
        logic        saturated;
    } res_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // one result bit of the digit-by-digit square root
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t            r;
        logic [SQ_RW-1:0] cur;
        logic [SQ_RW-1:0] trial;
        cur   = {s.rem[SQ_RW-3:0], s.rad[127:126]};
        trial = {{(SQ_RW-66){1'b0}}, s.root, 2'b01};
        r.rad = {s.rad[125:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {s.root[62:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {s.root[62:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of restoring division
    function automatic div_t div_step(input div_t s, input logic [DIV_DW-1:0] d);
        div_t              r;
        logic [DIV_RW-1:0] cur;
        cur   = {s.rem[DIV_RW-2:0], s.num[DIV_QW-1]};
        r.num = {s.num[DIV_QW-2:0], 1'b0};
        r.ovf = s.ovf;
        if (cur >= {1'b0, d})
        begin
            r.rem = cur - {1'b0, d};
            r.q   = {s.q[DIV_QW-2:0], 1'b1};
        end
        else
        begin
            r.rem = cur;
            r.q   = {s.q[DIV_QW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [63:0] clamp_term(input logic [DIV_QW-1:0] q, input logic ovf);
        return (ovf || (64'(q) > TERM_SAT)) ? TERM_SAT : 64'(q);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/esck_regs.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none

module esck_regs
    import esck_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [30:0] emit_x_reg;
    logic [30:0] emit_y_reg;
    logic [31:0] space_charge_reg;
    logic [31:0] dispersion_reg;
    logic [30:0] step_length_reg;
    reg_idx_t    idx;
    logic        wr;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_x_reg       <= '0;
            emit_y_reg       <= '0;
            space_charge_reg <= '0;
            dispersion_reg   <= '0;
            step_length_reg  <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_EMIT_X:       emit_x_reg       <= pwdata[30:0];
                REG_EMIT_Y:       emit_y_reg       <= pwdata[30:0];
                REG_SPACE_CHARGE: space_charge_reg <= pwdata;
                REG_DISPERSION:   dispersion_reg   <= pwdata;
                REG_STEP_LENGTH:  step_length_reg  <= pwdata[30:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_EMIT_X:       prdata = {1'b0, emit_x_reg};
            REG_EMIT_Y:       prdata = {1'b0, emit_y_reg};
            REG_SPACE_CHARGE: prdata = space_charge_reg;
            REG_DISPERSION:   prdata = dispersion_reg;
            REG_STEP_LENGTH:  prdata = {1'b0, step_length_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.emit_x       = emit_x_reg;
    assign cfg.emit_y       = emit_y_reg;
    assign cfg.space_charge = space_charge_reg;
    assign cfg.dispersion   = dispersion_reg;
    assign cfg.step_length  = step_length_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/esck_prep.sv -----
// Front stages: magnitudes, products, cubes and the square-root radicand.
`default_nettype none

module esck_prep
    import esck_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  src_valid,
    input  item_t src,
    input  cfg_t  cfg,
    output logic  dst_valid,
    output prep_t dst
);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] a2;
        logic [63:0] b2;
        logic [63:0] m;
        logic [61:0] ex2;
        logic [61:0] ey2;
        logic [31:0] x_slope;
        logic [31:0] y_slope;
    } p1_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] a2;
        logic [63:0] a3l;
        logic [62:0] a3h;
        logic [63:0] b3l;
        logic [62:0] b3h;
        logic [63:0] mll;
        logic [62:0] mlh;
        logic [61:0] mhh;
        logic [61:0] ex2;
        logic [61:0] ey2;
        logic [31:0] x_slope;
        logic [31:0] y_slope;
    } p2_t;

    logic [PREP_STAGES-1:0] vld_reg;
    p1_t   p1_reg, p1_next;
    p2_t   p2_reg, p2_next;
    prep_t p3_reg, p3_next;
    logic [31:0] a_mag, b_mag, d_mag, s_mag;
    logic [127:0] msq;

    always_comb
    begin
        a_mag = mag32(src.x_size);
        b_mag = mag32(src.y_size);
        d_mag = mag32(cfg.dispersion);
        s_mag = mag32(src.energy_spread);
        p1_next.a       = a_mag;
        p1_next.b       = b_mag;
        p1_next.a2      = 64'(a_mag) * 64'(a_mag);
        p1_next.b2      = 64'(b_mag) * 64'(b_mag);
        p1_next.m       = 64'(d_mag) * 64'(s_mag);
        p1_next.ex2     = 62'(cfg.emit_x) * 62'(cfg.emit_x);
        p1_next.ey2     = 62'(cfg.emit_y) * 62'(cfg.emit_y);
        p1_next.x_slope = src.x_slope;
        p1_next.y_slope = src.y_slope;
    end

    // cubes and |D*s|^2 split into 32-bit partial products
    always_comb
    begin
        p2_next.a       = p1_reg.a;
        p2_next.b       = p1_reg.b;
        p2_next.a2      = p1_reg.a2;
        p2_next.a3l     = 64'(p1_reg.a2[31:0]) * 64'(p1_reg.a);
        p2_next.a3h     = 63'(p1_reg.a2[62:32]) * 63'(p1_reg.a);
        p2_next.b3l     = 64'(p1_reg.b2[31:0]) * 64'(p1_reg.b);
        p2_next.b3h     = 63'(p1_reg.b2[62:32]) * 63'(p1_reg.b);
        p2_next.mll     = 64'(p1_reg.m[31:0]) * 64'(p1_reg.m[31:0]);
        p2_next.mlh     = 63'(p1_reg.m[31:0]) * 63'(p1_reg.m[62:32]);
        p2_next.mhh     = 62'(p1_reg.m[62:32]) * 62'(p1_reg.m[62:32]);
        p2_next.ex2     = p1_reg.ex2;
        p2_next.ey2     = p1_reg.ey2;
        p2_next.x_slope = p1_reg.x_slope;
        p2_next.y_slope = p1_reg.y_slope;
    end

    // radicand = a^2 * 2^32 + 4 * (D*s)^2
    always_comb
    begin
        msq = 128'(p2_reg.mll) + (128'(p2_reg.mlh) << 33) + (128'(p2_reg.mhh) << 64);
        p3_next.rad     = (128'(p2_reg.a2) << 32) + (msq << 2);
        p3_next.a3      = 96'(p2_reg.a3l) + (96'(p2_reg.a3h) << 32);
        p3_next.b3      = 96'(p2_reg.b3l) + (96'(p2_reg.b3h) << 32);
        p3_next.ex2     = p2_reg.ex2;
        p3_next.ey2     = p2_reg.ey2;
        p3_next.b       = p2_reg.b;
        p3_next.a_zero  = (p2_reg.a == '0);
        p3_next.b_zero  = (p2_reg.b == '0);
        p3_next.x_slope = p2_reg.x_slope;
        p3_next.y_slope = p2_reg.y_slope;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PREP_STAGES-2:0], src_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    assign dst_valid = vld_reg[PREP_STAGES-1];
    assign dst       = p3_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/esck_rootdiv.sv -----
// Square-root pipeline run side by side with the two emittance dividers.
`default_nettype none

module esck_rootdiv
    import esck_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  src_valid,
    input  prep_t src,
    output logic  dst_valid,
    output rd_t   dst
);

    logic [SQ_STEPS-1:0] vld_reg;
    rd_t st_reg  [SQ_STEPS];
    rd_t st_next [SQ_STEPS];
    sqrt_t sq0;

    always_comb
    begin
        sq0.rem  = '0;
        sq0.root = '0;
        sq0.rad  = src.rad;
        st_next[0].sq = sqrt_step(sq0);
        // quotient of emit^2 * 2^32 by size^3; top bits fold into the start remainder
        st_next[0].dx.rem = DIV_RW'(src.ex2[61:31]);
        st_next[0].dx.q   = '0;
        st_next[0].dx.num = {src.ex2[30:0], 32'b0};
        st_next[0].dx.ovf = (DIV_DW'(src.ex2[61:31]) >= src.a3);
        st_next[0].dy.rem = DIV_RW'(src.ey2[61:31]);
        st_next[0].dy.q   = '0;
        st_next[0].dy.num = {src.ey2[30:0], 32'b0};
        st_next[0].dy.ovf = (DIV_DW'(src.ey2[61:31]) >= src.b3);
        st_next[0].a3      = src.a3;
        st_next[0].b3      = src.b3;
        st_next[0].b       = src.b;
        st_next[0].a_zero  = src.a_zero;
        st_next[0].b_zero  = src.b_zero;
        st_next[0].x_slope = src.x_slope;
        st_next[0].y_slope = src.y_slope;
        for (int i = 1; i < SQ_STEPS; i++)
        begin
            st_next[i]    = st_reg[i-1];
            st_next[i].sq = sqrt_step(st_reg[i-1].sq);
            st_next[i].dx = div_step(st_reg[i-1].dx, st_reg[i-1].a3);
            st_next[i].dy = div_step(st_reg[i-1].dy, st_reg[i-1].b3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[SQ_STEPS-2:0], src_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign dst_valid = vld_reg[SQ_STEPS-1];
    assign dst       = st_reg[SQ_STEPS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/esck_kdiv.sv -----
// Forms t and divides 2|K| by it, one quotient bit per stage.
`default_nettype none

module esck_kdiv
    import esck_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic src_valid,
    input  rd_t  src,
    input  cfg_t cfg,
    output logic dst_valid,
    output kd_t  dst
);

    logic [KD_STEPS-1:0] vld_reg;
    kd_t  st_reg  [KD_STEPS];
    kd_t  st_next [KD_STEPS];
    logic [31:0] km;
    div_t first;

    assign km = mag32(cfg.space_charge);

    always_comb
    begin
        first = st_reg[0].dg;
        first.ovf = (first.rem >= DIV_RW'(st_reg[0].t));
        st_next[0].t       = src.sq.root + (64'(src.b) << 16);
        // numerator |K| * 2^33: bits from 2^63 up start the remainder
        st_next[0].dg.rem  = DIV_RW'(km[31:30]);
        st_next[0].dg.q    = '0;
        st_next[0].dg.num  = {km[29:0], 33'b0};
        st_next[0].dg.ovf  = 1'b0;
        st_next[0].qx      = src.dx.q;
        st_next[0].ovfx    = src.dx.ovf;
        st_next[0].qy      = src.dy.q;
        st_next[0].ovfy    = src.dy.ovf;
        st_next[0].a_zero  = src.a_zero;
        st_next[0].b_zero  = src.b_zero;
        st_next[0].x_slope = src.x_slope;
        st_next[0].y_slope = src.y_slope;
        st_next[1]    = st_reg[0];
        st_next[1].dg = div_step(first, DIV_DW'(st_reg[0].t));
        for (int i = 2; i < KD_STEPS; i++)
        begin
            st_next[i]    = st_reg[i-1];
            st_next[i].dg = div_step(st_reg[i-1].dg, DIV_DW'(st_reg[i-1].t));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[KD_STEPS-2:0], src_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign dst_valid = vld_reg[KD_STEPS-1];
    assign dst       = st_reg[KD_STEPS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/esck_kick.sv -----
// Back stages: term sums, kick = sum * L, slope update with saturation.
`default_nettype none

module esck_kick
    import esck_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic src_valid,
    input  kd_t  src,
    input  cfg_t cfg,
    output logic dst_valid,
    output res_t dst
);

    typedef struct packed {
        logic [63:0] tmx;
        logic        negx;
        logic [63:0] tmy;
        logic        negy;
        logic        a_zero;
        logic        b_zero;
        logic [31:0] x_slope;
        logic [31:0] y_slope;
    } c1_t;

    typedef struct packed {
        logic [62:0] plx;
        logic [62:0] phx;
        logic        negx;
        logic [62:0] ply;
        logic [62:0] phy;
        logic        negy;
        logic        a_zero;
        logic        b_zero;
        logic [31:0] x_slope;
        logic [31:0] y_slope;
    } c2_t;

    typedef struct packed {
        logic [40:0] kx;
        logic        negx;
        logic [40:0] ky;
        logic        negy;
        logic        a_zero;
        logic        b_zero;
        logic [31:0] x_slope;
        logic [31:0] y_slope;
    } c3_t;

    localparam logic signed [42:0] RES_MAX = 43'sd2147483647;
    localparam logic signed [42:0] RES_MIN = -43'sd2147483648;

    logic [KICK_STAGES-1:0] vld_reg;
    c1_t  c1_reg, c1_next;
    c2_t  c2_reg, c2_next;
    c3_t  c3_reg, c3_next;
    res_t c4_reg, c4_next;

    logic [63:0] gm, ex, ey;
    logic signed [64:0] gs, totx, toty;
    logic [94:0] prodx, prody;
    logic [78:0] shx, shy;
    logic signed [42:0] resx, resy;
    logic hix, lox, hiy, loy;
    logic [31:0] valx, valy;

    always_comb
    begin
        gm   = clamp_term(src.dg.q, src.dg.ovf);
        ex   = clamp_term(src.qx, src.ovfx);
        ey   = clamp_term(src.qy, src.ovfy);
        gs   = cfg.space_charge[31] ? -$signed({1'b0, gm}) : $signed({1'b0, gm});
        totx = $signed({1'b0, ex}) + gs;
        toty = $signed({1'b0, ey}) + gs;
        c1_next.negx    = totx[64];
        c1_next.tmx     = totx[64] ? 64'(-totx) : totx[63:0];
        c1_next.negy    = toty[64];
        c1_next.tmy     = toty[64] ? 64'(-toty) : toty[63:0];
        c1_next.a_zero  = src.a_zero;
        c1_next.b_zero  = src.b_zero;
        c1_next.x_slope = src.x_slope;
        c1_next.y_slope = src.y_slope;
    end

    always_comb
    begin
        c2_next.plx     = 63'(c1_reg.tmx[31:0]) * 63'(cfg.step_length);
        c2_next.phx     = 63'(c1_reg.tmx[63:32]) * 63'(cfg.step_length);
        c2_next.ply     = 63'(c1_reg.tmy[31:0]) * 63'(cfg.step_length);
        c2_next.phy     = 63'(c1_reg.tmy[63:32]) * 63'(cfg.step_length);
        c2_next.negx    = c1_reg.negx;
        c2_next.negy    = c1_reg.negy;
        c2_next.a_zero  = c1_reg.a_zero;
        c2_next.b_zero  = c1_reg.b_zero;
        c2_next.x_slope = c1_reg.x_slope;
        c2_next.y_slope = c1_reg.y_slope;
    end

    // drop 16 fraction bits, clamp kick magnitude to 2^40
    always_comb
    begin
        prodx = 95'(c2_reg.plx) + (95'(c2_reg.phx) << 32);
        prody = 95'(c2_reg.ply) + (95'(c2_reg.phy) << 32);
        shx   = prodx[94:16];
        shy   = prody[94:16];
        c3_next.kx      = (shx > 79'(KICK_SAT)) ? KICK_SAT : shx[40:0];
        c3_next.ky      = (shy > 79'(KICK_SAT)) ? KICK_SAT : shy[40:0];
        c3_next.negx    = c2_reg.negx;
        c3_next.negy    = c2_reg.negy;
        c3_next.a_zero  = c2_reg.a_zero;
        c3_next.b_zero  = c2_reg.b_zero;
        c3_next.x_slope = c2_reg.x_slope;
        c3_next.y_slope = c2_reg.y_slope;
    end

    always_comb
    begin
        resx = $signed({{11{c3_reg.x_slope[31]}}, c3_reg.x_slope})
             + (c3_reg.negx ? -$signed({2'b0, c3_reg.kx}) : $signed({2'b0, c3_reg.kx}));
        resy = $signed({{11{c3_reg.y_slope[31]}}, c3_reg.y_slope})
             + (c3_reg.negy ? -$signed({2'b0, c3_reg.ky}) : $signed({2'b0, c3_reg.ky}));
        hix  = resx > RES_MAX;
        lox  = resx < RES_MIN;
        hiy  = resy > RES_MAX;
        loy  = resy < RES_MIN;
        valx = hix ? SLOPE_MAX : (lox ? SLOPE_MIN : resx[31:0]);
        valy = hiy ? SLOPE_MAX : (loy ? SLOPE_MIN : resy[31:0]);
        // zero size: no emittance term, pinned to the positive bound
        c4_next.new_x_slope = c3_reg.a_zero ? SLOPE_MAX : valx;
        c4_next.new_y_slope = c3_reg.b_zero ? SLOPE_MAX : valy;
        c4_next.saturated   = c3_reg.a_zero || c3_reg.b_zero || hix || lox || hiy || loy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[KICK_STAGES-2:0], src_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
            c4_reg <= c4_next;
        end
    end

    assign dst_valid = vld_reg[KICK_STAGES-1];
    assign dst       = c4_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/envelope_space_charge_kick_unit.sv -----
// Top level of the envelope space-charge kick unit.
// One envelope word in, one kicked-slope word out, one word per clock sustained while the sink keeps up.
// The pipe is built of 3 front stages (magnitudes, products, radicand), 64
// square-root stages that also carry the two emittance dividers, 64 stages for
// t and the 2K/t divider, 4 kick stages and the output register. The root and
// the dividers each retire one result bit per stage, which sets that depth.
// The whole pipe advances together; it holds only when the last stage and the
// output register both carry a word that the sink has not taken, so a new
// word is still accepted while a finished one waits. Configuration registers
// are read live by the stages and must be written while the pipe is empty.
// saturated (tuser) is set for a zero size or a slope clamped to 32 bits.
`default_nettype none

module envelope_space_charge_kick_unit
    import esck_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // x_size, x_slope, y_size, y_slope, energy_spread
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // new_x_slope, new_y_slope
    output logic         m_tuser,   // saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t  cfg;
    item_t item;
    logic  en;
    logic  out_free;

    logic  prep_valid, rd_valid, kd_valid, tail_valid;
    prep_t prep_word;
    rd_t   rd_word;
    kd_t   kd_word;
    res_t  tail_word;

    logic  out_valid_reg, out_valid_next;
    res_t  out_reg;

    assign item.x_size        = s_tdata[31:0];
    assign item.x_slope       = s_tdata[63:32];
    assign item.y_size        = s_tdata[95:64];
    assign item.y_slope       = s_tdata[127:96];
    assign item.energy_spread = s_tdata[159:128];

    // output register can take a word this cycle
    assign out_free = !out_valid_reg || m_tready;
    // pipe moves unless its last word is stuck behind the output register
    assign en       = !tail_valid || out_free;
    assign s_tready = en;

    esck_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esck_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (s_tvalid),
        .src       (item),
        .cfg       (cfg),
        .dst_valid (prep_valid),
        .dst       (prep_word)
    );

    esck_rootdiv u_rootdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (prep_valid),
        .src       (prep_word),
        .dst_valid (rd_valid),
        .dst       (rd_word)
    );

    esck_kdiv u_kdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (rd_valid),
        .src       (rd_word),
        .cfg       (cfg),
        .dst_valid (kd_valid),
        .dst       (kd_word)
    );

    esck_kick u_kick (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (kd_valid),
        .src       (kd_word),
        .cfg       (cfg),
        .dst_valid (tail_valid),
        .dst       (tail_word)
    );

    always_comb
    begin
        if (tail_valid && out_free)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tail_valid && out_free)
            out_reg <= tail_word;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.new_y_slope, out_reg.new_x_slope};
    assign m_tuser  = out_reg.saturated;

endmodule

`default_nettype wire

// ----- hw/rtl/esck_checker.sv -----
// Port-level checks of the kick unit, bound to the top level.
`default_nettype none

module esck_checker
    import esck_pkg::*;
(
    input wire         clk,
    input wire         rst_n,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [63:0]  m_tdata,
    input wire         m_tuser,
    input wire         psel,
    input wire         penable,
    input wire         pwrite,
    input wire [4:0]   paddr,
    input wire [31:0]  pwdata,
    input wire [31:0]  prdata,
    input wire         pready
);

    logic [7:0] cnt_reg, cnt_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
            cnt_next = cnt_reg + 8'd1;
        else if (out_acc && !in_acc)
            cnt_next = cnt_reg - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // held result word does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // input side only stalls behind an untaken result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // no result without a word in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt_reg != 8'd0)
        else $error("result word with nothing in flight");

    // space charge register reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr == {REG_SPACE_CHARGE, 2'b00}
        ##1 psel && !pwrite && paddr == {REG_SPACE_CHARGE, 2'b00}
        |-> prdata == $past(pwdata))
        else $error("register read-back mismatch");

endmodule

bind envelope_space_charge_kick_unit esck_checker u_esck_checker (.*);

`default_nettype wire
